// ----- sv/usb_bulk_only_storage_transport_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bulk-only transport block
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef USB_BULK_ONLY_STORAGE_TRANSPORT_MACROS_SVH
`define USB_BULK_ONLY_STORAGE_TRANSPORT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while the active-low reset is asserted.
`define BOT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define BOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BOT_ASSERT(lbl, clk, rstn, prop, msg)
`define BOT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/bot_pkg.sv -----
// ----------------------------------------------------------------------------
// Bulk-only transport package
// Item and result types, opcodes and action codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bot_pkg;

    localparam logic [31:0] WRAPPER_SIG   = 32'h4342_5355;
    localparam logic [12:0] SECTOR_RESET  = 13'd512;
    localparam logic [27:0] BYTES_MAX     = 28'hFFF_FFFF;

    // SCSI opcodes
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
    localparam logic [7:0] OP_START_STOP      = 8'h1B;
    localparam logic [7:0] OP_ALLOW_REMOVAL   = 8'h1E;
    localparam logic [7:0] OP_FORMAT_CAPS     = 8'h23;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_READ10          = 8'h28;
    localparam logic [7:0] OP_WRITE10         = 8'h2A;
    localparam logic [7:0] OP_VERIFY10        = 8'h2F;

    // Endpoint event kinds
    localparam logic CMD_BULK_OUT = 1'b0;
    localparam logic CMD_BULK_IN  = 1'b1;

    // Actions
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_SEND   = 3'd1;
    localparam logic [2:0] ACT_REPLY  = 3'd2;
    localparam logic [2:0] ACT_STATUS = 3'd3;
    localparam logic [2:0] ACT_ARM    = 3'd4;

    // Reply kinds
    localparam logic [2:0] RK_SENSE       = 3'd0;
    localparam logic [2:0] RK_INQUIRY     = 3'd1;
    localparam logic [2:0] RK_MODE_SENSE6 = 3'd2;
    localparam logic [2:0] RK_FORMAT_CAPS = 3'd3;
    localparam logic [2:0] RK_CAPACITY    = 3'd4;

    // Register addresses (word index)
    localparam logic REG_SECTOR_BYTES = 1'b0;

    typedef struct packed {
        logic        cmd;
        logic [31:0] wrapper_signature;
        logic [31:0] wrapper_tag;
        logic [31:0] host_length;
        logic [7:0]  scsi_opcode;
        logic [31:0] logical_block;
        logic [15:0] block_total;
        logic [12:0] rx_bytes;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        store_sector;
        logic [31:0] block_addr;
        logic [2:0]  reply_kind;
        logic [31:0] status_tag;
        logic [31:0] status_residue;
        logic        status_code;
        logic        rejected;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/bot_cfg.sv -----
// ----------------------------------------------------------------------------
// Bulk-only transport configuration registers
// APB register file holding the sector size.
// ----------------------------------------------------------------------------
`default_nettype none

module bot_cfg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [12:0]      sector_bytes
);

    logic [12:0] sector_bytes_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == bot_pkg::REG_SECTOR_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_bytes_reg <= bot_pkg::SECTOR_RESET;
        end else if (wr_en) begin
            sector_bytes_reg <= pwdata[12:0];
        end
    end

    assign prdata = (paddr[2] == bot_pkg::REG_SECTOR_BYTES) ? {19'd0, sector_bytes_reg} : 32'd0;
    assign sector_bytes = sector_bytes_reg;

endmodule

`default_nettype wire

// ----- sv/bot_core.sv -----
// ----------------------------------------------------------------------------
// Bulk-only transport decision core
// Transport phase and counters; decodes one event into one action.
// ----------------------------------------------------------------------------
`default_nettype none

module bot_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire bot_pkg::item_t  item,
    input  wire logic [28:0]     write_bytes,
    output bot_pkg::result_t     result
);

    typedef enum logic [1:0] {
        PH_COMMAND,
        PH_STATUS,
        PH_RECEIVE,
        PH_SEND
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] next_block_reg, next_block_next;
    logic [15:0] blocks_left_reg, blocks_left_next;
    logic [27:0] bytes_left_reg, bytes_left_next;
    logic [31:0] saved_tag_reg, saved_tag_next;
    logic [31:0] residue_reg, residue_next;
    logic        removed_reg, removed_next;

    logic [27:0] bytes_sub;
    logic [31:0] residue_sub;
    logic [15:0] blocks_dec;
    logic [15:0] read_dec;
    logic [27:0] bytes_sat;

    always_comb begin
        bytes_sub = (bytes_left_reg > {15'd0, item.rx_bytes})
                  ? bytes_left_reg - {15'd0, item.rx_bytes} : 28'd0;
        residue_sub = (residue_reg > {19'd0, item.rx_bytes})
                    ? residue_reg - {19'd0, item.rx_bytes} : 32'd0;
        blocks_dec = (blocks_left_reg != 16'd0) ? blocks_left_reg - 16'd1 : 16'd0;
        read_dec   = item.block_total - 16'd1;
        bytes_sat  = write_bytes[28] ? bot_pkg::BYTES_MAX : write_bytes[27:0];

        phase_next       = phase_reg;
        next_block_next  = next_block_reg;
        blocks_left_next = blocks_left_reg;
        bytes_left_next  = bytes_left_reg;
        saved_tag_next   = saved_tag_reg;
        residue_next     = residue_reg;
        removed_next     = removed_reg;
        result           = '0;

        if (item.cmd == bot_pkg::CMD_BULK_OUT) begin
            unique case (phase_reg)
                PH_COMMAND: begin
                    if (item.wrapper_signature != bot_pkg::WRAPPER_SIG) begin
                        result.rejected = 1'b1;
                    end else begin
                        saved_tag_next = item.wrapper_tag;
                        residue_next   = 32'd0;
                        unique case (item.scsi_opcode)
                            bot_pkg::OP_TEST_UNIT_READY: begin
                                result.action      = bot_pkg::ACT_STATUS;
                                result.status_tag  = item.wrapper_tag;
                                result.status_code = removed_reg;
                                phase_next         = PH_COMMAND;
                            end
                            bot_pkg::OP_REQUEST_SENSE: begin
                                result.action     = bot_pkg::ACT_REPLY;
                                result.reply_kind = bot_pkg::RK_SENSE;
                                phase_next        = PH_STATUS;
                            end
                            bot_pkg::OP_INQUIRY: begin
                                result.action     = bot_pkg::ACT_REPLY;
                                result.reply_kind = bot_pkg::RK_INQUIRY;
                                phase_next        = PH_STATUS;
                            end
                            bot_pkg::OP_MODE_SENSE6: begin
                                result.action     = bot_pkg::ACT_REPLY;
                                result.reply_kind = bot_pkg::RK_MODE_SENSE6;
                                phase_next        = PH_STATUS;
                            end
                            bot_pkg::OP_FORMAT_CAPS: begin
                                result.action     = bot_pkg::ACT_REPLY;
                                result.reply_kind = bot_pkg::RK_FORMAT_CAPS;
                                phase_next        = PH_STATUS;
                            end
                            bot_pkg::OP_READ_CAPACITY: begin
                                result.action     = bot_pkg::ACT_REPLY;
                                result.reply_kind = bot_pkg::RK_CAPACITY;
                                phase_next        = PH_STATUS;
                            end
                            bot_pkg::OP_ALLOW_REMOVAL, bot_pkg::OP_VERIFY10: begin
                                result.action     = bot_pkg::ACT_STATUS;
                                result.status_tag = item.wrapper_tag;
                                phase_next        = PH_COMMAND;
                            end
                            bot_pkg::OP_START_STOP: begin
                                removed_next      = 1'b1;
                                result.action     = bot_pkg::ACT_STATUS;
                                result.status_tag = item.wrapper_tag;
                                phase_next        = PH_COMMAND;
                            end
                            bot_pkg::OP_READ10: begin
                                if (item.block_total == 16'd0) begin
                                    result.action     = bot_pkg::ACT_STATUS;
                                    result.status_tag = item.wrapper_tag;
                                    phase_next        = PH_COMMAND;
                                end else begin
                                    // first sector goes out with the command
                                    result.action    = bot_pkg::ACT_SEND;
                                    result.block_addr = item.logical_block;
                                    blocks_left_next = read_dec;
                                    if (read_dec != 16'd0) begin
                                        next_block_next = item.logical_block + 32'd1;
                                        phase_next      = PH_SEND;
                                    end else begin
                                        next_block_next = item.logical_block;
                                        phase_next      = PH_STATUS;
                                    end
                                end
                            end
                            bot_pkg::OP_WRITE10: begin
                                residue_next    = item.host_length;
                                bytes_left_next = bytes_sat;
                                next_block_next = item.logical_block;
                                if (bytes_sat == 28'd0) begin
                                    result.action         = bot_pkg::ACT_STATUS;
                                    result.status_tag     = item.wrapper_tag;
                                    result.status_residue = item.host_length;
                                    phase_next            = PH_COMMAND;
                                end else begin
                                    result.action = bot_pkg::ACT_ARM;
                                    phase_next    = PH_RECEIVE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                PH_RECEIVE: begin
                    bytes_left_next     = bytes_sub;
                    residue_next        = residue_sub;
                    result.store_sector = 1'b1;
                    result.block_addr   = next_block_reg;
                    next_block_next     = next_block_reg + 32'd1;
                    if (bytes_sub == 28'd0) begin
                        result.action         = bot_pkg::ACT_STATUS;
                        result.status_tag     = saved_tag_reg;
                        result.status_residue = residue_sub;
                        phase_next            = PH_COMMAND;
                    end else begin
                        result.action = bot_pkg::ACT_ARM;
                    end
                end
                PH_STATUS, PH_SEND: begin
                    result.rejected = 1'b1;
                end
            endcase
        end else begin
            unique case (phase_reg)
                PH_STATUS: begin
                    result.action         = bot_pkg::ACT_STATUS;
                    result.status_tag     = saved_tag_reg;
                    result.status_residue = residue_reg;
                    phase_next            = PH_COMMAND;
                end
                PH_SEND: begin
                    result.action     = bot_pkg::ACT_SEND;
                    result.block_addr = next_block_reg;
                    blocks_left_next  = blocks_dec;
                    if (blocks_dec != 16'd0) begin
                        next_block_next = next_block_reg + 32'd1;
                    end else begin
                        phase_next = PH_STATUS;
                    end
                end
                PH_COMMAND, PH_RECEIVE: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_COMMAND;
            next_block_reg  <= 32'd0;
            blocks_left_reg <= 16'd0;
            bytes_left_reg  <= 28'd0;
            saved_tag_reg   <= 32'd0;
            residue_reg     <= 32'd0;
            removed_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            next_block_reg  <= next_block_next;
            blocks_left_reg <= blocks_left_next;
            bytes_left_reg  <= bytes_left_next;
            saved_tag_reg   <= saved_tag_next;
            residue_reg     <= residue_next;
            removed_reg     <= removed_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/usb_bulk_only_storage_transport.sv -----
// ----------------------------------------------------------------------------
// USB mass-storage bulk-only transport, device side
// Dataflow: an accepted item is held in the input register; its result loads
// the result register when the item advances, and is taken from there.
// Throughput: one item per cycle while the result register is free or draining.
// Reset (aresetn low, synchronous): command phase, counters, tag and residue
// zero, medium present, sector size 512, both pipeline stages empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "usb_bulk_only_storage_transport_macros.svh"

module usb_bulk_only_storage_transport (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input endpoint events
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata, low bit up: wrapper_signature[31:0], wrapper_tag[63:32],
    // host_length[95:64], scsi_opcode[103:96], logical_block[135:104],
    // block_total[151:136], rx_bytes[164:152], zero fill[167:165]
    input  wire logic [167:0] s_tdata,
    // s_tuser: cmd[0]
    input  wire logic [0:0]   s_tuser,
    // result actions
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata, low bit up: store_sector[0], block_addr[32:1], reply_kind[35:33],
    // status_tag[67:36], status_residue[99:68], status_code[100],
    // rejected[101], zero fill[103:102]
    output logic [103:0]      m_tdata,
    // m_tuser: action[2:0]
    output logic [2:0]        m_tuser,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    bot_pkg::item_t   s_item;
    bot_pkg::item_t   in_item_reg;
    logic [28:0]      in_bytes_reg;
    logic             in_valid_reg;
    bot_pkg::result_t core_res;
    bot_pkg::result_t out_res_reg;
    logic             out_valid_reg;
    logic             advance;
    logic [12:0]      sector_bytes;

    bot_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sector_bytes (sector_bytes)
    );

    // Unpack the incoming item
    always_comb begin
        s_item.cmd               = s_tuser[0];
        s_item.wrapper_signature = s_tdata[31:0];
        s_item.wrapper_tag       = s_tdata[63:32];
        s_item.host_length       = s_tdata[95:64];
        s_item.scsi_opcode       = s_tdata[103:96];
        s_item.logical_block     = s_tdata[135:104];
        s_item.block_total       = s_tdata[151:136];
        s_item.rx_bytes          = s_tdata[164:152];
    end

    // Move the held item into the core when the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new item whenever the input register empties this cycle.
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture payload with the write byte count; the multiply sits ahead of
    // the input register so the decision path carries only the saturation.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg  <= s_item;
            in_bytes_reg <= {13'd0, s_item.block_total} * {16'd0, sector_bytes};
        end
    end

    bot_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item_reg),
        .write_bytes (in_bytes_reg),
        .result      (core_res)
    );

    // Result register: fill on advance, drain on handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {2'b00,
                       out_res_reg.rejected,
                       out_res_reg.status_code,
                       out_res_reg.status_residue,
                       out_res_reg.status_tag,
                       out_res_reg.reply_kind,
                       out_res_reg.block_addr,
                       out_res_reg.store_sector};

    // A stored sector always comes with a rearm or a closing status.
    `BOT_ASSERT(a_store_action, aclk, aresetn, (m_tvalid && out_res_reg.store_sector) |-> (out_res_reg.action == bot_pkg::ACT_ARM || out_res_reg.action == bot_pkg::ACT_STATUS), "store without arm or status")
    // A rejected item carries no action.
    `BOT_ASSERT(a_reject_none, aclk, aresetn, (m_tvalid && out_res_reg.rejected) |-> (out_res_reg.action == bot_pkg::ACT_NONE), "rejected item with action")
    // A failed status code only appears in a status wrapper.
    `BOT_ASSERT(a_code_status, aclk, aresetn, (m_tvalid && out_res_reg.status_code) |-> (out_res_reg.action == bot_pkg::ACT_STATUS), "status code outside status")
    // A new result only appears after an item was held at the input.
    `BOT_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid) |-> $past(in_valid_reg), "result without held item")

endmodule

`default_nettype wire

// ----- tb/sv/bot_transport_checker.sv -----
// ----------------------------------------------------------------------------
// Bulk-only transport action checker
// Watches the event, action and register ports of the transport block, keeps
// its own copy of the transfer state, predicts one action per accepted event
// and compares every returned action, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module bot_transport_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [167:0] s_tdata,
    input  wire logic [0:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic [2:0]   m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic         pready,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output int                n_errors,
    output int                n_pending
);

    typedef enum logic [1:0] {
        XF_COMMAND,
        XF_STATUS,
        XF_RECEIVE,
        XF_SEND
    } xfer_phase_t;

    xfer_phase_t xfer_phase;
    logic [12:0] sector_len;
    logic [31:0] blk_next;
    logic [15:0] blk_remaining;
    logic [27:0] byte_remaining;
    logic [31:0] tag_latched;
    logic [31:0] residue_left;
    logic        medium_out;

    bot_pkg::result_t actions_due[$];

    function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    // Close the command: status wrapper, back to waiting for a wrapper.
    task automatic close_status(inout bot_pkg::result_t act, input logic code);
        act.action         = bot_pkg::ACT_STATUS;
        act.status_tag     = tag_latched;
        act.status_residue = residue_left;
        act.status_code    = code;
        xfer_phase         = XF_COMMAND;
    endtask

    task automatic give_reply(inout bot_pkg::result_t act, input logic [2:0] kind);
        act.action     = bot_pkg::ACT_REPLY;
        act.reply_kind = kind;
        xfer_phase     = XF_STATUS;
    endtask

    task automatic emit_sector(inout bot_pkg::result_t act);
        act.action     = bot_pkg::ACT_SEND;
        act.block_addr = blk_next;
        if (blk_remaining != 16'd0) begin
            blk_remaining = blk_remaining - 16'd1;
        end
        if (blk_remaining != 16'd0) begin
            blk_next   = blk_next + 32'd1;
            xfer_phase = XF_SEND;
        end else begin
            xfer_phase = XF_STATUS;
        end
    endtask

    task automatic advance_transport(input bot_pkg::item_t ev,
                                     output bot_pkg::result_t act);
        logic [28:0] prod;
        act = '0;
        if (ev.cmd == bot_pkg::CMD_BULK_OUT) begin
            if (xfer_phase == XF_COMMAND) begin
                if (ev.wrapper_signature != bot_pkg::WRAPPER_SIG) begin
                    act.rejected = 1'b1;
                end else begin
                    tag_latched  = ev.wrapper_tag;
                    residue_left = 32'd0;
                    case (ev.scsi_opcode)
                        bot_pkg::OP_TEST_UNIT_READY: close_status(act, medium_out);
                        bot_pkg::OP_REQUEST_SENSE:   give_reply(act, bot_pkg::RK_SENSE);
                        bot_pkg::OP_INQUIRY:         give_reply(act, bot_pkg::RK_INQUIRY);
                        bot_pkg::OP_MODE_SENSE6:     give_reply(act, bot_pkg::RK_MODE_SENSE6);
                        bot_pkg::OP_FORMAT_CAPS:     give_reply(act, bot_pkg::RK_FORMAT_CAPS);
                        bot_pkg::OP_READ_CAPACITY:   give_reply(act, bot_pkg::RK_CAPACITY);
                        bot_pkg::OP_ALLOW_REMOVAL, bot_pkg::OP_VERIFY10:
                            close_status(act, 1'b0);
                        bot_pkg::OP_START_STOP: begin
                            medium_out = 1'b1;
                            close_status(act, 1'b0);
                        end
                        bot_pkg::OP_READ10: begin
                            if (ev.block_total == 16'd0) begin
                                close_status(act, 1'b0);
                            end else begin
                                blk_next      = ev.logical_block;
                                blk_remaining = ev.block_total;
                                emit_sector(act);
                            end
                        end
                        bot_pkg::OP_WRITE10: begin
                            residue_left   = ev.host_length;
                            prod           = ev.block_total * sector_len;
                            byte_remaining = (prod > bot_pkg::BYTES_MAX)
                                           ? bot_pkg::BYTES_MAX : prod[27:0];
                            blk_next       = ev.logical_block;
                            if (byte_remaining == 28'd0) begin
                                close_status(act, 1'b0);
                            end else begin
                                act.action = bot_pkg::ACT_ARM;
                                xfer_phase = XF_RECEIVE;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (xfer_phase == XF_RECEIVE) begin
                byte_remaining   = 28'(floor_sub({4'd0, byte_remaining}, {19'd0, ev.rx_bytes}));
                residue_left     = floor_sub(residue_left, {19'd0, ev.rx_bytes});
                act.store_sector = 1'b1;
                act.block_addr   = blk_next;
                blk_next         = blk_next + 32'd1;
                if (byte_remaining == 28'd0) begin
                    close_status(act, 1'b0);
                end else begin
                    act.action = bot_pkg::ACT_ARM;
                end
            end else begin
                act.rejected = 1'b1;
            end
        end else begin
            if (xfer_phase == XF_STATUS) begin
                close_status(act, 1'b0);
            end else if (xfer_phase == XF_SEND) begin
                emit_sector(act);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
            n_errors = n_errors + 1;
        end
    endtask

    always @(posedge aclk) begin
        bot_pkg::item_t   ev;
        bot_pkg::result_t want;
        bot_pkg::result_t got;
        if (!aresetn) begin
            xfer_phase     = XF_COMMAND;
            sector_len     = bot_pkg::SECTOR_RESET;
            blk_next       = '0;
            blk_remaining  = '0;
            byte_remaining = '0;
            tag_latched    = '0;
            residue_left   = '0;
            medium_out     = 1'b0;
            n_errors       = 0;
            actions_due.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[2] == bot_pkg::REG_SECTOR_BYTES) begin
                sector_len = pwdata[12:0];
            end
            if (m_tvalid && m_tready) begin
                got.action         = m_tuser;
                got.store_sector   = m_tdata[0];
                got.block_addr     = m_tdata[32:1];
                got.reply_kind     = m_tdata[35:33];
                got.status_tag     = m_tdata[67:36];
                got.status_residue = m_tdata[99:68];
                got.status_code    = m_tdata[100];
                got.rejected       = m_tdata[101];
                if (actions_due.size() == 0) begin
                    $display("%0t: action with none due, expected nothing, actual %h",
                             $time, got);
                    n_errors = n_errors + 1;
                end else begin
                    want = actions_due.pop_front();
                    check_field("action", 32'(want.action), 32'(got.action));
                    check_field("store_sector", 32'(want.store_sector),
                                32'(got.store_sector));
                    check_field("block_addr", want.block_addr, got.block_addr);
                    check_field("reply_kind", 32'(want.reply_kind), 32'(got.reply_kind));
                    check_field("status_tag", want.status_tag, got.status_tag);
                    check_field("status_residue", want.status_residue, got.status_residue);
                    check_field("status_code", 32'(want.status_code), 32'(got.status_code));
                    check_field("rejected", 32'(want.rejected), 32'(got.rejected));
                end
            end
            if (s_tvalid && s_tready) begin
                ev.cmd               = s_tuser[0];
                ev.wrapper_signature = s_tdata[31:0];
                ev.wrapper_tag       = s_tdata[63:32];
                ev.host_length       = s_tdata[95:64];
                ev.scsi_opcode       = s_tdata[103:96];
                ev.logical_block     = s_tdata[135:104];
                ev.block_total       = s_tdata[151:136];
                ev.rx_bytes          = s_tdata[164:152];
                advance_transport(ev, want);
                actions_due.push_back(want);
            end
        end
        n_pending <= actions_due.size();
    end

endmodule

// ----- tb/sv/tb_usb_bulk_only_storage_transport.sv -----
// ----------------------------------------------------------------------------
// Bulk-only transport testbench
// Drives endpoint events and sector-size writes into the transport block,
// first a directed pass over every command and corner, then random command
// sequences under four sector sizes. A checker beside the block predicts and
// compares every action; this module only makes stimulus and gives a verdict.
// ----------------------------------------------------------------------------
module tb_usb_bulk_only_storage_transport;

    // Cycles with nothing accepted on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 100;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // s_tdata, low bit up: wrapper_signature, wrapper_tag, host_length,
    // scsi_opcode, logical_block, block_total, rx_bytes, zero fill
    logic [167:0] s_tdata;
    // s_tuser: cmd
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // m_tdata, low bit up: store_sector, block_addr, reply_kind, status_tag,
    // status_residue, status_code, rejected, zero fill
    logic [103:0] m_tdata;
    // m_tuser: action
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int           mismatch_count;
    int           actions_pending;
    int           items_sent;
    int           idle_cycles;
    int           hold_left;
    int           sector_now;
    logic         quiet;
    logic         hold_go;
    logic         hold_done;

    usb_bulk_only_storage_transport i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bot_transport_checker i_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .n_errors (mismatch_count),
        .n_pending(actions_pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Receiver: random back-pressure, none while quiet, and one long hold-off
    // once the stimulus raises hold_go. The sender keeps offering meanwhile,
    // so the block fills up and drops s_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 26);
        end
    end

    // Watchdog: abandon the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where penable and pready are both high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_sector_size(input int bytes);
        sector_now = bytes;
        apb_write({bot_pkg::REG_SECTOR_BYTES, 2'b00}, bytes);
    endtask

    // Offer one item, with a random gap first unless quiet; hold it until taken.
    task automatic offer(input bot_pkg::item_t ev);
        if (!quiet && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 26);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.cmd;
        s_tdata  <= {3'b000, ev.rx_bytes, ev.block_total, ev.logical_block, ev.scsi_opcode,
                     ev.host_length, ev.wrapper_tag, ev.wrapper_signature};
        do @(posedge aclk); while (!s_tready);
        items_sent = items_sent + 1;
    endtask

    // Drop valid and wait until every action due has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (actions_pending != 0) @(posedge aclk);
    endtask

    function automatic bot_pkg::item_t random_item;
        bot_pkg::item_t ev;
        ev.cmd               = 1'($urandom_range(0, 1));
        ev.wrapper_signature = $urandom;
        ev.wrapper_tag       = $urandom;
        ev.host_length       = $urandom;
        ev.scsi_opcode       = 8'($urandom);
        ev.logical_block     = $urandom;
        ev.block_total       = 16'($urandom);
        ev.rx_bytes          = 13'($urandom_range(0, 4096));
        return ev;
    endfunction

    function automatic bot_pkg::item_t wrapper(input logic [7:0] op, input logic [31:0] tag,
                                               input logic [31:0] hlen,
                                               input logic [31:0] lba,
                                               input logic [15:0] cnt);
        bot_pkg::item_t ev;
        ev                   = random_item();
        ev.cmd               = bot_pkg::CMD_BULK_OUT;
        ev.wrapper_signature = bot_pkg::WRAPPER_SIG;
        ev.wrapper_tag       = tag;
        ev.host_length       = hlen;
        ev.scsi_opcode       = op;
        ev.logical_block     = lba;
        ev.block_total       = cnt;
        return ev;
    endfunction

    function automatic bot_pkg::item_t forged_wrapper;
        bot_pkg::item_t ev;
        ev     = random_item();
        ev.cmd = bot_pkg::CMD_BULK_OUT;
        if (ev.wrapper_signature == bot_pkg::WRAPPER_SIG) begin
            ev.wrapper_signature = ~bot_pkg::WRAPPER_SIG;
        end
        return ev;
    endfunction

    function automatic bot_pkg::item_t bulk_in_done;
        bot_pkg::item_t ev;
        ev     = random_item();
        ev.cmd = bot_pkg::CMD_BULK_IN;
        return ev;
    endfunction

    function automatic bot_pkg::item_t data_packet(input logic [12:0] rx);
        bot_pkg::item_t ev;
        ev          = random_item();
        ev.cmd      = bot_pkg::CMD_BULK_OUT;
        ev.rx_bytes = rx;
        return ev;
    endfunction

    // One random command with its whole data and status exchange, or a
    // stray event that leaves the command phase untouched.
    task automatic run_command;
        int          pick;
        int          k;
        logic [7:0]  op;
        logic [15:0] cnt;
        logic [31:0] lba;
        logic [31:0] hlen;
        logic [12:0] rx;
        int unsigned bytes_due;
        if ($urandom_range(0, 99) < 20) begin
            if ($urandom_range(0, 1) == 0) begin
                offer(bulk_in_done());
            end else begin
                offer(forged_wrapper());
            end
        end else begin
            pick = $urandom_range(0, 15);
            cnt  = 16'($urandom);
            lba  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
            hlen = $urandom;
            case (pick)
                0:       op = bot_pkg::OP_TEST_UNIT_READY;
                1:       op = bot_pkg::OP_ALLOW_REMOVAL;
                2:       op = bot_pkg::OP_VERIFY10;
                3:       op = bot_pkg::OP_START_STOP;
                4:       op = bot_pkg::OP_REQUEST_SENSE;
                5:       op = bot_pkg::OP_INQUIRY;
                6:       op = bot_pkg::OP_MODE_SENSE6;
                7:       op = bot_pkg::OP_FORMAT_CAPS;
                8:       op = bot_pkg::OP_READ_CAPACITY;
                // above the highest opcode the block decodes
                9:       op = 8'($urandom_range(8'h30, 8'hFF));
                10, 11, 12: op = bot_pkg::OP_READ10;
                default: op = bot_pkg::OP_WRITE10;
            endcase
            if (pick >= 4 && pick <= 8) begin
                // reply, then its bulk-in completion closes with status
                offer(wrapper(op, $urandom, hlen, lba, cnt));
                if ($urandom_range(0, 4) == 0) begin
                    offer(data_packet(13'($urandom_range(0, 4096))));
                end
                offer(bulk_in_done());
            end else if (op == bot_pkg::OP_READ10) begin
                k = $urandom_range(0, 19);
                if (k == 0) cnt = 16'd0;
                else if (k == 1) cnt = 16'($urandom_range(5, 24));
                else cnt = 16'($urandom_range(1, 4));
                offer(wrapper(op, $urandom, hlen, lba, cnt));
                // one completion per remaining sector, one more for status
                repeat (cnt) begin
                    if ($urandom_range(0, 9) == 0) begin
                        offer(data_packet(13'($urandom_range(0, 4096))));
                    end
                    offer(bulk_in_done());
                end
            end else if (op == bot_pkg::OP_WRITE10) begin
                cnt = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
                bytes_due = cnt * sector_now;
                k = $urandom_range(0, 3);
                if (k == 0) hlen = bytes_due;
                else if (k == 1) hlen = $urandom_range(0, 1000);
                offer(wrapper(op, $urandom, hlen, lba, cnt));
                while (bytes_due != 0) begin
                    if ($urandom_range(0, 6) == 0) offer(bulk_in_done());
                    k = $urandom_range(0, 9);
                    if (k < 7) rx = 13'(sector_now);
                    else if (k < 9) rx = 13'($urandom_range(0, 4096));
                    else rx = 13'd4096;
                    bytes_due = (rx >= bytes_due) ? 0 : bytes_due - rx;
                    offer(data_packet(rx));
                end
            end else begin
                offer(wrapper(op, $urandom, hlen, lba, cnt));
            end
        end
    endtask

    initial begin
        int phase_end;
        // Drive every input to a known value from time zero.
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        m_tready   <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        quiet      <= 1'b0;
        hold_go    <= 1'b0;
        items_sent = 0;
        sector_now = bot_pkg::SECTOR_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Address past the only register: the block drops the write.
        apb_write(3'd4, $urandom);

        // Directed pass at the reset sector size.
        offer(wrapper(bot_pkg::OP_TEST_UNIT_READY, 32'd0, 32'd0, 32'd0, 16'd0));
        offer(wrapper(bot_pkg::OP_REQUEST_SENSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 16'hFFFF));
        offer(bulk_in_done());
        offer(wrapper(bot_pkg::OP_INQUIRY, $urandom, $urandom, $urandom, 16'hFFFF));
        offer(bulk_in_done());
        offer(wrapper(bot_pkg::OP_MODE_SENSE6, $urandom, $urandom, $urandom, 16'($urandom)));
        offer(bulk_in_done());
        offer(wrapper(bot_pkg::OP_FORMAT_CAPS, $urandom, $urandom, $urandom, 16'($urandom)));
        offer(bulk_in_done());
        offer(wrapper(bot_pkg::OP_READ_CAPACITY, $urandom, $urandom, $urandom,
                      16'($urandom)));
        offer(bulk_in_done());
        offer(wrapper(bot_pkg::OP_ALLOW_REMOVAL, $urandom, $urandom, $urandom,
                      16'($urandom)));
        offer(wrapper(bot_pkg::OP_VERIFY10, $urandom, $urandom, $urandom, 16'($urandom)));
        // opcode the block does not know: no action, tag still latched
        offer(wrapper(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        offer(forged_wrapper());
        // completion while waiting for a wrapper
        offer(bulk_in_done());
        // two-sector read across the top of the block address space, with a
        // bulk-out packet refused in the middle
        offer(wrapper(bot_pkg::OP_READ10, $urandom, $urandom, 32'hFFFF_FFFF, 16'd2));
        offer(data_packet(13'd0));
        offer(bulk_in_done());
        offer(bulk_in_done());
        // zero-length read and write go straight to status
        offer(wrapper(bot_pkg::OP_READ10, $urandom, $urandom, $urandom, 16'd0));
        offer(wrapper(bot_pkg::OP_WRITE10, $urandom, 32'hFFFF_FFFF, $urandom, 16'd0));
        // one-sector write: empty packet, stray completion, oversized packet
        // that floors both the byte count and the residue at zero
        offer(wrapper(bot_pkg::OP_WRITE10, $urandom, 32'd100, 32'hFFFF_FFFF, 16'd1));
        offer(data_packet(13'd0));
        offer(bulk_in_done());
        offer(data_packet(13'd4096));
        // eject the medium; unit-ready reports failure from now on
        offer(wrapper(bot_pkg::OP_START_STOP, $urandom, $urandom, $urandom, 16'($urandom)));
        offer(wrapper(bot_pkg::OP_TEST_UNIT_READY, $urandom, $urandom, $urandom,
                      16'($urandom)));
        drain();

        // Random phases: largest sector with the long hold-off, a random size,
        // smallest sector with no idling anywhere, another random size.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_sector_size(4096);
                2:       set_sector_size(512);
                default: set_sector_size($urandom_range(512, 4096));
            endcase
            quiet   <= (ph == 2);
            hold_go <= (ph == 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_command();
            drain();
        end

        // Let the two-stage pipeline settle, then give the verdict.
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bot_pkg.sv
sv/bot_cfg.sv
sv/bot_core.sv
sv/usb_bulk_only_storage_transport.sv
tb/sv/bot_transport_checker.sv
tb/sv/tb_usb_bulk_only_storage_transport.sv
